// File: hw/rtl/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants of the tape-language machine core
// Symbol codes, operation codes, status codes and the queued item type.
// ----------------------------------------------------------------------------
package bfm_pkg;

    localparam int TAPE_CELLS    = 4096;
    localparam int PROGRAM_DEPTH = 4096;
    localparam int CELL_W        = $clog2(TAPE_CELLS);
    localparam int PADDR_W       = $clog2(PROGRAM_DEPTH);
    localparam int PC_W          = 13;
    localparam int DATA_W        = 32;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_NEW    = 2'd2;
    localparam logic [1:0] OP_STEP   = 2'd3;

    localparam logic [2:0] ST_RUN          = 3'd0;
    localparam logic [2:0] ST_END          = 3'd1;
    localparam logic [2:0] ST_PAST_END     = 3'd2;
    localparam logic [2:0] ST_BEFORE_START = 3'd3;
    localparam logic [2:0] ST_NO_CLOSE     = 3'd4;
    localparam logic [2:0] ST_NO_OPEN      = 3'd5;

    localparam logic [7:0] SYM_INC   = 8'h2B;
    localparam logic [7:0] SYM_DEC   = 8'h2D;
    localparam logic [7:0] SYM_RIGHT = 8'h3E;
    localparam logic [7:0] SYM_LEFT  = 8'h3C;
    localparam logic [7:0] SYM_OUT   = 8'h2E;
    localparam logic [7:0] SYM_IN    = 8'h2C;
    localparam logic [7:0] SYM_OPEN  = 8'h5B;
    localparam logic [7:0] SYM_CLOSE = 8'h5D;

    typedef struct packed {
        logic [1:0]        operation;
        logic [7:0]        symbol;
        logic [DATA_W-1:0] in_value;
    } item_t;

endpackage

// File: hw/rtl/bfm_ram.sv
// ----------------------------------------------------------------------------
// bfm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/bfm_front.sv
// ----------------------------------------------------------------------------
// bfm_front: command intake
// Takes command beats into a two-entry queue that feeds the execution unit.
// ----------------------------------------------------------------------------
module bfm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bfm_pkg::item_t push_item,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output bfm_pkg::item_t q_item
);
    import bfm_pkg::*;

    item_t      slot_reg [2];
    logic       wptr_reg;
    logic       wptr_next;
    logic       rptr_reg;
    logic       rptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = do_pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/bfm_back.sv
// ----------------------------------------------------------------------------
// bfm_back: execution unit
// Runs queued commands against the program store and the tape.
// ----------------------------------------------------------------------------
module bfm_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  bfm_pkg::item_t             q_item,
    output logic                       pop,
    output logic                       done,
    output logic                       out_valid,
    output logic [7:0]                 out_byte,
    output logic [2:0]                 status,
    output logic [bfm_pkg::PC_W-1:0]   program_counter,
    output logic [bfm_pkg::CELL_W-1:0] cell_pointer_out
);
    import bfm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_FWD    = 3'd3;
    localparam logic [2:0] S_FWD_CK = 3'd4;
    localparam logic [2:0] S_BWD    = 3'd5;
    localparam logic [2:0] S_BWD_CK = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [PC_W-1:0]   len_reg, len_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              halted_reg, halted_next;
    logic [2:0]        hcode_reg, hcode_next;
    logic [CELL_W-1:0] clr_reg, clr_next;
    logic              clr_emit_reg, clr_emit_next;
    logic [PC_W-1:0]   pos_reg, pos_next;
    logic [PC_W-1:0]   depth_reg, depth_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              done_reg, done_next;
    logic              ov_reg, ov_next;
    logic [7:0]        ob_reg, ob_next;
    logic [2:0]        st_reg, st_next;

    logic               p_we;
    logic [PADDR_W-1:0] p_raddr;
    logic [7:0]         p_rdata;
    logic               t_we;
    logic [CELL_W-1:0]  t_waddr;
    logic [DATA_W-1:0]  t_wdata;
    logic [DATA_W-1:0]  t_rdata;
    logic [PC_W-1:0]    pos_inc;
    logic [PC_W-1:0]    pos_dec;

    assign pos_inc = pos_reg + 1'b1;
    assign pos_dec = pos_reg - 1'b1;
    assign pop     = (state_reg == S_IDLE);
    assign p_we    = pop && q_valid && (q_item.operation == OP_APPEND)
                     && (len_reg < PC_W'(PROGRAM_DEPTH));

    bfm_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
        .clk   (clk),
        .we    (p_we),
        .waddr (len_reg[PADDR_W-1:0]),
        .wdata (q_item.symbol),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    bfm_ram #(.WIDTH(DATA_W), .DEPTH(TAPE_CELLS)) u_tape (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (cell_reg),
        .rdata (t_rdata)
    );

    always_comb
    begin
        unique case (state_reg)
            S_FWD:   p_raddr = pos_inc[PADDR_W-1:0];
            S_BWD:   p_raddr = pos_dec[PADDR_W-1:0];
            default: p_raddr = pc_reg[PADDR_W-1:0];
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        len_next      = len_reg;
        cell_next     = cell_reg;
        halted_next   = halted_reg;
        hcode_next    = hcode_reg;
        clr_next      = clr_reg;
        clr_emit_next = clr_emit_reg;
        pos_next      = pos_reg;
        depth_next    = depth_reg;
        val_next      = val_reg;
        done_next     = 1'b0;
        ov_next       = 1'b0;
        ob_next       = 8'd0;
        st_next       = ST_RUN;
        t_we          = 1'b0;
        t_waddr       = cell_reg;
        t_wdata       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.operation)
                        OP_APPEND:
                        begin
                            if (p_we)
                            begin
                                len_next = len_reg + 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            clr_next      = '0;
                            clr_emit_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        OP_NEW:
                        begin
                            len_next    = '0;
                            pc_next     = '0;
                            halted_next = 1'b0;
                            hcode_next  = ST_RUN;
                            done_next   = 1'b1;
                        end
                        default:
                        begin
                            if (halted_reg)
                            begin
                                st_next   = hcode_reg;
                                done_next = 1'b1;
                            end
                            else if (pc_reg >= len_reg)
                            begin
                                st_next   = ST_END;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                val_next   = q_item.in_value;
                                state_next = S_EXEC;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                t_we    = 1'b1;
                t_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CELL_W'(TAPE_CELLS - 1))
                begin
                    cell_next  = '0;
                    done_next  = clr_emit_reg;
                    state_next = S_IDLE;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                pc_next    = pc_reg + 1'b1;
                case (p_rdata)
                    SYM_INC:
                    begin
                        t_we    = 1'b1;
                        t_wdata = t_rdata + 1'b1;
                    end
                    SYM_DEC:
                    begin
                        t_we    = 1'b1;
                        t_wdata = t_rdata - 1'b1;
                    end
                    SYM_IN:
                    begin
                        t_we    = 1'b1;
                        t_wdata = val_reg;
                    end
                    SYM_OUT:
                    begin
                        ov_next = 1'b1;
                        ob_next = t_rdata[7:0];
                    end
                    SYM_RIGHT:
                    begin
                        if (cell_reg == CELL_W'(TAPE_CELLS - 1))
                        begin
                            pc_next     = pc_reg;
                            halted_next = 1'b1;
                            hcode_next  = ST_PAST_END;
                            st_next     = ST_PAST_END;
                        end
                        else
                        begin
                            cell_next = cell_reg + 1'b1;
                        end
                    end
                    SYM_LEFT:
                    begin
                        if (cell_reg == '0)
                        begin
                            pc_next     = pc_reg;
                            halted_next = 1'b1;
                            hcode_next  = ST_BEFORE_START;
                            st_next     = ST_BEFORE_START;
                        end
                        else
                        begin
                            cell_next = cell_reg - 1'b1;
                        end
                    end
                    SYM_OPEN:
                    begin
                        if (t_rdata == '0)
                        begin
                            pc_next    = pc_reg;
                            done_next  = 1'b0;
                            pos_next   = pc_reg;
                            depth_next = PC_W'(1);
                            state_next = S_FWD;
                        end
                    end
                    SYM_CLOSE:
                    begin
                        if (t_rdata != '0)
                        begin
                            pc_next    = pc_reg;
                            done_next  = 1'b0;
                            pos_next   = pc_reg;
                            depth_next = PC_W'(1);
                            state_next = S_BWD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FWD:
            begin
                if (pos_inc >= len_reg)
                begin
                    halted_next = 1'b1;
                    hcode_next  = ST_NO_CLOSE;
                    st_next     = ST_NO_CLOSE;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = S_FWD_CK;
                end
            end
            S_FWD_CK:
            begin
                state_next = S_FWD;
                if (p_rdata == SYM_OPEN)
                begin
                    depth_next = depth_reg + 1'b1;
                end
                else if (p_rdata == SYM_CLOSE)
                begin
                    depth_next = depth_reg - 1'b1;
                    if (depth_reg == PC_W'(1))
                    begin
                        pc_next    = pos_inc;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_BWD:
            begin
                if (pos_reg == '0)
                begin
                    halted_next = 1'b1;
                    hcode_next  = ST_NO_OPEN;
                    st_next     = ST_NO_OPEN;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    pos_next   = pos_dec;
                    state_next = S_BWD_CK;
                end
            end
            S_BWD_CK:
            begin
                state_next = S_BWD;
                if (p_rdata == SYM_CLOSE)
                begin
                    depth_next = depth_reg + 1'b1;
                end
                else if (p_rdata == SYM_OPEN)
                begin
                    depth_next = depth_reg - 1'b1;
                    if (depth_reg == PC_W'(1))
                    begin
                        pc_next    = pos_inc;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        pos_reg   <= pos_next;
        depth_reg <= depth_next;
        ob_reg    <= ob_next;
        st_reg    <= st_next;
    end

    // After reset the tape is swept to zero without reporting a result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            pc_reg       <= '0;
            len_reg      <= '0;
            cell_reg     <= '0;
            halted_reg   <= 1'b0;
            hcode_reg    <= ST_RUN;
            clr_reg      <= '0;
            clr_emit_reg <= 1'b0;
            done_reg     <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            len_reg      <= len_next;
            cell_reg     <= cell_next;
            halted_reg   <= halted_next;
            hcode_reg    <= hcode_next;
            clr_reg      <= clr_next;
            clr_emit_reg <= clr_emit_next;
            done_reg     <= done_next;
            ov_reg       <= ov_next;
        end
    end

    assign done             = done_reg;
    assign out_valid        = ov_reg;
    assign out_byte         = ob_reg;
    assign status           = st_reg;
    assign program_counter  = pc_reg;
    assign cell_pointer_out = cell_reg;

endmodule

// File: hw/rtl/brainfuck_machine_core.sv
// ----------------------------------------------------------------------------
// brainfuck_machine_core: eight-symbol tape-language machine
// Appends program symbols, clears the tape, restarts programs and steps them.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Handshake               Payload
// command    in         start && !busy          operation, symbol, in_value
// result     out        done (one cycle only)   out_valid, out_byte, status,
//                                               program_counter, cell_pointer_out
//
// Every command beat yields exactly one result beat, in order. Append, new
// program and halted or finished steps finish in the idle state of the
// execution unit; a simple symbol first reads the program and the tape, then
// writes the tape. A bracket scan walks the program one symbol at a time,
// reading each from the single read port of the program store and then
// checking it. Clearing the tape sweeps all 4096 cells, one per cycle, and
// the same sweep runs after reset. A two-entry command queue lets the host
// issue commands while the execution unit works; busy rises only when that
// queue is full. The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module brainfuck_machine_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 operation,
    input  logic [7:0]                 symbol,
    input  logic signed [31:0]         in_value,
    output logic                       done,
    output logic                       out_valid,
    output logic [7:0]                 out_byte,
    output logic [2:0]                 status,
    output logic [bfm_pkg::PC_W-1:0]   program_counter,
    output logic [bfm_pkg::CELL_W-1:0] cell_pointer_out
);
    import bfm_pkg::*;

    item_t in_item;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;
    logic  q_full;

    // Command beats are packed into one item for the queue.
    assign in_item.operation = operation;
    assign in_item.symbol    = symbol;
    assign in_item.in_value  = in_value;
    assign busy              = q_full;

    bfm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !q_full),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // The execution unit takes one queued item whenever it is idle.
    bfm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .pop              (q_pop),
        .done             (done),
        .out_valid        (out_valid),
        .out_byte         (out_byte),
        .status           (status),
        .program_counter  (program_counter),
        .cell_pointer_out (cell_pointer_out)
    );

    // An output byte only comes from a symbol that ran without error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_valid) |-> (status == ST_RUN))
        else $error("output byte reported with an error status");

    // Nothing is reported as an output byte outside a result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !out_valid)
        else $error("output flag raised without a result beat");

    // The status code never leaves the defined range.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= ST_NO_OPEN))
        else $error("status code out of range");

endmodule
